// ===== hw/rtl/dbe_pkg.sv =====
// shared constants, types and the shared unit request/response structs
// for the delay and bandwidth estimator; no dependencies
package dbe_pkg;

  localparam int FRAC_BITS    = 16;
  localparam int ALPHA_FRAC   = 16;
  localparam int ALPHA_W      = ALPHA_FRAC + 1;
  localparam int TS_W         = 64;
  localparam int BYTES_W      = 16;
  localparam int DELAY_W      = 32;
  localparam int CNT_W        = 32;
  localparam int BW_INT_W     = 40;
  localparam int DLY_Q_W      = DELAY_W + FRAC_BITS;
  localparam int BW_Q_W       = BW_INT_W + FRAC_BITS;
  localparam int RATE_SCALE_W = 23;
  localparam int PROD_W       = BYTES_W + RATE_SCALE_W;
  localparam int NUM_W        = PROD_W + FRAC_BITS;
  localparam int VAL_W        = BW_Q_W;
  localparam int ACC_W        = VAL_W + ALPHA_W + 1;

  localparam logic [ALPHA_W-1:0]      ALPHA_ONE  = ALPHA_W'(1) << ALPHA_FRAC;
  localparam logic [ALPHA_W-1:0]      ALPHA_RST  = ALPHA_W'(6554);
  localparam logic [RATE_SCALE_W-1:0] RATE_SCALE = RATE_SCALE_W'(8000000);

  typedef enum logic {
    OP_EWMA,
    OP_DIV
  } dbe_op_e;

  typedef struct packed {
    logic    start;
    dbe_op_e op;
  } dbe_alu_req_t;

  typedef struct packed {
    logic idle;
    logic done;
  } dbe_alu_rsp_t;

endpackage

// ===== hw/rtl/dbe_cfg_if.sv =====
// configuration write channel carrying the alpha register
// depends on dbe_pkg
interface dbe_cfg_if import dbe_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [ALPHA_W-1:0] alpha_q16;

  modport source (output valid, output alpha_q16, input ready);
  modport sink   (input valid, input alpha_q16, output ready);
endinterface

// ===== hw/rtl/dbe_in_if.sv =====
// probe observation channel: send time, receive time and size
// depends on dbe_pkg
interface dbe_in_if import dbe_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [TS_W-1:0]    send_time_us;
  logic [TS_W-1:0]    recv_time_us;
  logic [BYTES_W-1:0] probe_bytes;

  modport source (output valid, output send_time_us, output recv_time_us,
                  output probe_bytes, input ready);
  modport sink   (input valid, input send_time_us, input recv_time_us,
                  input probe_bytes, output ready);
endinterface

// ===== hw/rtl/dbe_out_if.sv =====
// result channel: status and a snapshot of the estimates
// depends on dbe_pkg
interface dbe_out_if import dbe_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                status;
  logic [DELAY_W-1:0]  delay_smoothed;
  logic [DELAY_W-1:0]  delay_min;
  logic [DELAY_W-1:0]  delay_max;
  logic [BW_INT_W-1:0] bandwidth_bps;
  logic [CNT_W-1:0]    sample_total;

  modport source (output valid, output status, output delay_smoothed,
                  output delay_min, output delay_max, output bandwidth_bps,
                  output sample_total, input ready);
  modport sink   (input valid, input status, input delay_smoothed,
                  input delay_min, input delay_max, input bandwidth_bps,
                  input sample_total, output ready);
endinterface

// ===== hw/rtl/dbe_alu.sv =====
// shared iterative unit: ewma step by shift-add multiply, or restoring divide
// one adder serves every step; depends on dbe_pkg
module dbe_alu import dbe_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  dbe_alu_req_t       req_i,
  input  logic [VAL_W-1:0]   old_i,
  input  logic [VAL_W-1:0]   x_i,
  input  logic [ALPHA_W-1:0] alpha_i,
  input  logic [NUM_W-1:0]   num_i,
  input  logic [TS_W-1:0]    den_i,
  output dbe_alu_rsp_t       rsp_o,
  output logic [VAL_W-1:0]   result_o
);

  localparam int STEP_W = $clog2(NUM_W);
  localparam logic [ACC_W-1:0] EWMA_HALF = ACC_W'(1) << (ALPHA_FRAC - 1);

  typedef enum logic [2:0] {
    A_IDLE,
    A_DIFF,
    A_MUL,
    A_RND,
    A_FIN,
    A_DIV,
    A_DONE
  } alu_state_e;

  alu_state_e        state_q;
  dbe_op_e           op_q;
  logic [ACC_W-1:0]  acc_q;
  logic [ACC_W-1:0]  opb_q;
  logic [NUM_W-1:0]  aux_q;
  logic [VAL_W-1:0]  old_q;
  logic [STEP_W-1:0] step_q;

  logic [ACC_W-1:0] add_a, add_b, add_sum;
  logic             add_sub;
  logic [ACC_W-1:0] old_ext, acc_shr, rem_sh;

  assign old_ext = {{(ACC_W-VAL_W){1'b0}}, old_q};
  assign acc_shr = unsigned'($signed(acc_q) >>> ALPHA_FRAC);
  // next partial remainder: shift in the top numerator bit
  assign rem_sh  = {acc_q[ACC_W-2:0], aux_q[NUM_W-1]};

  always_comb begin
    add_a   = acc_q;
    add_b   = '0;
    add_sub = 1'b0;
    case (state_q)
      A_DIFF: begin
        add_b   = old_ext;
        add_sub = 1'b1;
      end
      A_MUL: begin
        add_b = aux_q[0] ? opb_q : '0;
      end
      A_RND: begin
        add_b = EWMA_HALF;
      end
      A_FIN: begin
        add_a = old_ext;
        add_b = acc_shr;
      end
      A_DIV: begin
        add_a   = rem_sh;
        add_b   = opb_q;
        add_sub = 1'b1;
      end
      default: begin
        add_b = '0;
      end
    endcase
  end

  assign add_sum = add_a + (add_sub ? ~add_b : add_b) + {{(ACC_W-1){1'b0}}, add_sub};

  // new = old + ((a * (x - old) + half) >>> 16), equal to the weighted form
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= A_IDLE;
      op_q    <= OP_EWMA;
      acc_q   <= '0;
      opb_q   <= '0;
      aux_q   <= '0;
      old_q   <= '0;
      step_q  <= '0;
    end else begin
      case (state_q)
        A_IDLE: begin
          if (req_i.start) begin
            op_q   <= req_i.op;
            step_q <= '0;
            if (req_i.op == OP_EWMA) begin
              acc_q   <= {{(ACC_W-VAL_W){1'b0}}, x_i};
              old_q   <= old_i;
              aux_q   <= {{(NUM_W-ALPHA_W){1'b0}}, alpha_i};
              state_q <= A_DIFF;
            end else begin
              acc_q   <= '0;
              opb_q   <= {{(ACC_W-TS_W){1'b0}}, den_i};
              aux_q   <= num_i;
              state_q <= A_DIV;
            end
          end
        end
        A_DIFF: begin
          opb_q   <= add_sum;
          acc_q   <= '0;
          state_q <= A_MUL;
        end
        A_MUL: begin
          acc_q  <= add_sum;
          opb_q  <= {opb_q[ACC_W-2:0], 1'b0};
          aux_q  <= aux_q >> 1;
          step_q <= step_q + STEP_W'(1);
          if (step_q == STEP_W'(ALPHA_W - 1)) begin
            state_q <= A_RND;
          end
        end
        A_RND: begin
          acc_q   <= add_sum;
          state_q <= A_FIN;
        end
        A_FIN: begin
          acc_q   <= add_sum;
          state_q <= A_DONE;
        end
        A_DIV: begin
          // negative trial keeps the shifted remainder
          acc_q  <= add_sum[ACC_W-1] ? rem_sh : add_sum;
          aux_q  <= {aux_q[NUM_W-2:0], ~add_sum[ACC_W-1]};
          step_q <= step_q + STEP_W'(1);
          if (step_q == STEP_W'(NUM_W - 1)) begin
            state_q <= A_DONE;
          end
        end
        A_DONE: begin
          state_q <= A_IDLE;
        end
        default: begin
          state_q <= A_IDLE;
        end
      endcase
    end
  end

  assign rsp_o.idle = (state_q == A_IDLE);
  assign rsp_o.done = (state_q == A_DONE);
  assign result_o   = (op_q == OP_DIV) ? {{(VAL_W-NUM_W){1'b0}}, aux_q}
                                       : acc_q[VAL_W-1:0];

endmodule

// ===== hw/rtl/delay_bandwidth_estimator_unit.sv =====
// Estimates one-way delay (smoothed, min, max) and smoothed bandwidth from
// probe beats, one result beat per probe. A rejected probe (received before
// it was sent) goes straight to the result register; an accepted probe first
// updates the delay figures and, when a bandwidth sample is possible, the rate
// and its average (an empty average takes the first rate directly). The work
// runs on the shared unit: a 17-step shift-add multiply per average and a
// 55-step restoring divide for the rate, one adder for all. A new probe is
// taken from the cycle after the previous one has reached the result
// register, which waits while an earlier result beat is still held off.
// depends on dbe_pkg, dbe_cfg_if, dbe_in_if, dbe_out_if, dbe_alu
module delay_bandwidth_estimator_unit import dbe_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  dbe_cfg_if.sink   cfg_i,
  dbe_in_if.sink    in_i,
  dbe_out_if.source out_o
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DELAY,
    S_GAP,
    S_DEWMA,
    S_DWAIT,
    S_BW,
    S_DIVWAIT,
    S_BWUPD,
    S_BWAIT,
    S_COMMIT,
    S_OUT
  } state_e;

  state_e state_q;

  logic [ALPHA_W-1:0] alpha_q;
  logic [DLY_Q_W-1:0] sd_q;
  logic [DELAY_W-1:0] least_q;
  logic [DELAY_W-1:0] greatest_q;
  logic [BW_Q_W-1:0]  sbw_q;
  logic [CNT_W-1:0]   cnt_q;
  logic [TS_W-1:0]    last_q;

  logic [TS_W-1:0]    send_q;
  logic [TS_W-1:0]    recv_q;
  logic [BYTES_W-1:0] bytes_q;
  logic [DELAY_W-1:0] delay_q;
  logic               rej_q;
  logic               bw_ok_q;
  logic [PROD_W-1:0]  num_q;
  logic [TS_W-1:0]    gap_q;
  logic [BW_Q_W-1:0]  rate_q;

  logic                out_valid_q;
  logic                out_status_q;
  logic [DELAY_W-1:0]  out_sd_q;
  logic [DELAY_W-1:0]  out_min_q;
  logic [DELAY_W-1:0]  out_max_q;
  logic [BW_INT_W-1:0] out_bw_q;
  logic [CNT_W-1:0]    out_cnt_q;

  logic [TS_W:0]        d_diff;
  logic [DELAY_W-1:0]   delay_sat;
  logic [ALPHA_W-1:0]   alpha_used;
  logic [DLY_Q_W-1:0]   dq;
  logic                 out_free;

  dbe_alu_req_t     alu_req;
  dbe_alu_rsp_t     alu_rsp;
  logic [VAL_W-1:0] alu_old, alu_x, alu_result;

  assign d_diff     = {1'b0, recv_q} - {1'b0, send_q};
  assign delay_sat  = (|d_diff[TS_W-1:DELAY_W]) ? '1 : d_diff[DELAY_W-1:0];
  assign alpha_used = (alpha_q > ALPHA_ONE) ? ALPHA_ONE : alpha_q;
  assign dq         = {delay_q, {FRAC_BITS{1'b0}}};
  assign out_free   = !out_valid_q || out_o.ready;

  assign alu_req.start = (state_q == S_DEWMA) || (state_q == S_BW && bw_ok_q) ||
                         (state_q == S_BWUPD && sbw_q != '0);
  assign alu_req.op    = (state_q == S_BW) ? OP_DIV : OP_EWMA;
  assign alu_old = (state_q == S_BWUPD) ? sbw_q : {{(VAL_W-DLY_Q_W){1'b0}}, sd_q};
  assign alu_x   = (state_q == S_BWUPD) ? rate_q : {{(VAL_W-DLY_Q_W){1'b0}}, dq};

  dbe_alu u_alu (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (alu_req),
    .old_i    (alu_old),
    .x_i      (alu_x),
    .alpha_i  (alpha_used),
    .num_i    ({num_q, {FRAC_BITS{1'b0}}}),
    .den_i    (gap_q),
    .rsp_o    (alu_rsp),
    .result_o (alu_result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      alpha_q      <= ALPHA_RST;
      sd_q         <= '0;
      least_q      <= '1;
      greatest_q   <= '0;
      sbw_q        <= '0;
      cnt_q        <= '0;
      last_q       <= '0;
      send_q       <= '0;
      recv_q       <= '0;
      bytes_q      <= '0;
      delay_q      <= '0;
      rej_q        <= 1'b0;
      bw_ok_q      <= 1'b0;
      num_q        <= '0;
      gap_q        <= '0;
      rate_q       <= '0;
      out_valid_q  <= 1'b0;
      out_status_q <= 1'b0;
      out_sd_q     <= '0;
      out_min_q    <= '0;
      out_max_q    <= '0;
      out_bw_q     <= '0;
      out_cnt_q    <= '0;
    end else begin
      if (cfg_i.valid) begin
        alpha_q <= cfg_i.alpha_q16;
      end
      // the result state reloads the register itself
      if (out_valid_q && out_o.ready && state_q != S_OUT) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_i.valid) begin
            send_q  <= in_i.send_time_us;
            recv_q  <= in_i.recv_time_us;
            bytes_q <= in_i.probe_bytes;
            state_q <= S_DELAY;
          end
        end
        S_DELAY: begin
          // borrow out of the subtract means receive precedes send
          rej_q   <= d_diff[TS_W];
          delay_q <= delay_sat;
          num_q   <= PROD_W'(bytes_q) * PROD_W'(RATE_SCALE);
          state_q <= d_diff[TS_W] ? S_OUT : S_GAP;
        end
        S_GAP: begin
          gap_q   <= recv_q - last_q;
          bw_ok_q <= (last_q != '0) && (recv_q > last_q) && (bytes_q != '0);
          if (cnt_q == '0 || delay_q < least_q) begin
            least_q <= delay_q;
          end
          if (delay_q > greatest_q) begin
            greatest_q <= delay_q;
          end
          if (cnt_q == '0) begin
            sd_q    <= dq;
            state_q <= S_BW;
          end else begin
            state_q <= S_DEWMA;
          end
        end
        S_DEWMA: begin
          state_q <= S_DWAIT;
        end
        S_DWAIT: begin
          if (alu_rsp.done) begin
            sd_q    <= alu_result[DLY_Q_W-1:0];
            state_q <= S_BW;
          end
        end
        S_BW: begin
          state_q <= bw_ok_q ? S_DIVWAIT : S_COMMIT;
        end
        S_DIVWAIT: begin
          if (alu_rsp.done) begin
            rate_q  <= alu_result;
            state_q <= S_BWUPD;
          end
        end
        S_BWUPD: begin
          // an empty average loads the first rate directly
          if (sbw_q == '0) begin
            sbw_q   <= rate_q;
            state_q <= S_COMMIT;
          end else begin
            state_q <= S_BWAIT;
          end
        end
        S_BWAIT: begin
          if (alu_rsp.done) begin
            sbw_q   <= alu_result;
            state_q <= S_COMMIT;
          end
        end
        S_COMMIT: begin
          last_q <= recv_q;
          if (cnt_q != '1) begin
            cnt_q <= cnt_q + CNT_W'(1);
          end
          state_q <= S_OUT;
        end
        S_OUT: begin
          if (out_free) begin
            out_valid_q  <= 1'b1;
            out_status_q <= rej_q;
            out_sd_q     <= sd_q[DLY_Q_W-1:FRAC_BITS];
            out_min_q    <= (cnt_q == '0) ? '0 : least_q;
            out_max_q    <= greatest_q;
            out_bw_q     <= sbw_q[BW_Q_W-1:FRAC_BITS];
            out_cnt_q    <= cnt_q;
            state_q      <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign cfg_i.ready = 1'b1;
  assign in_i.ready  = (state_q == S_IDLE);

  assign out_o.valid          = out_valid_q;
  assign out_o.status         = out_status_q;
  assign out_o.delay_smoothed = out_sd_q;
  assign out_o.delay_min      = out_min_q;
  assign out_o.delay_max      = out_max_q;
  assign out_o.bandwidth_bps  = out_bw_q;
  assign out_o.sample_total   = out_cnt_q;

  // count moves only when a probe commits
  a_cnt_commit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q != $past(cnt_q)) |-> ($past(state_q) == S_COMMIT))
    else $error("sample count changed outside commit");

  a_min_le_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q != '0) |-> (least_q <= greatest_q))
    else $error("least delay above greatest delay");

  a_alu_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    alu_req.start |-> alu_rsp.idle)
    else $error("shared unit started while busy");

  a_out_from_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == S_OUT))
    else $error("result beat raised outside result state");

endmodule
